// ===== design/sync_header_frame_parser_unit_defines.svh =====
// assertion helpers for the frame parser unit
`ifndef SYNC_HEADER_FRAME_PARSER_UNIT_DEFINES_SVH
`define SYNC_HEADER_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SHFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shfp assertion failed");

// next-cycle implication, checked out of reset
`define SHFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shfp assertion failed");

`endif

// ===== design/shfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package shfp_pkg;

  // frame layout
  localparam int FRAME_BYTES = 16;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam int PAYLOAD_W   = 96;
  localparam int SUM_W       = 12;
  localparam int CHK_W       = 16;

  localparam logic [7:0]       SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]       SYNC_SECOND = 8'h55;
  localparam logic [CNT_W-1:0] FIRST_DATA  = CNT_W'(2);
  localparam logic [CNT_W-1:0] PAYLOAD_END = CNT_W'(14);
  localparam logic [CNT_W-1:0] LAST_IDX    = CNT_W'(FRAME_BYTES - 1);

  // sync phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_SECOND  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_t;

  // control from the sequencer to the payload path
  typedef struct packed {
    logic shift_en;
    logic hi_en;
    logic clear;
  } path_ctl_t;

endpackage
`default_nettype wire

// ===== design/shfp_payload_path.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shfp_payload_path
  import shfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire path_ctl_t            ctl,
  input  wire logic [7:0]           rx_byte,
  output logic      [PAYLOAD_W-1:0] payload,
  output logic      [SUM_W-1:0]     sum,
  output logic      [7:0]           hi_byte
);

  logic [PAYLOAD_W-1:0] payload_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_nxt;
  logic [7:0]           hi_r;

  // payload bytes enter at the top, so the first one ends at bit 0
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      payload_r <= {rx_byte, payload_r[PAYLOAD_W-1:8]};
    end
    if (ctl.hi_en) begin
      hi_r <= rx_byte;
    end
  end

  // running additive checksum
  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.shift_en) begin
      sum_nxt = sum_r + SUM_W'(rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign payload = payload_r;
  assign sum     = sum_r;
  assign hi_byte = hi_r;

endmodule
`default_nettype wire

// ===== design/sync_header_frame_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sync_header_frame_parser_unit_defines.svh"
// Byte-stream frame parser: takes one received byte per request, hunts for the
// sync pair 0xAA 0x55 and then collects the rest of a 16-byte frame. Bytes 2..13
// come out as three little-endian 32-bit words together with checksum_ok, which
// is set when their 16-bit sum equals byte 14 (high) and byte 15 (low). Every
// byte is taken straight into the state register; the result of a frame is
// in the output register the cycle after its last byte is taken. A byte is
// accepted every cycle; a waiting result holds the input back only when the
// next byte would close another frame.
module sync_header_frame_parser_unit
  import shfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_payload_word0,
  output logic      [31:0] out_payload_word1,
  output logic      [31:0] out_payload_word2,
  output logic             out_checksum_ok
);

  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          word0_r, word1_r, word2_r;
  logic                 ok_r;
  logic                 in_accept;
  logic                 last_byte;
  logic                 emit;
  logic                 sum_match;
  path_ctl_t            ctl;
  logic [PAYLOAD_W-1:0] payload;
  logic [SUM_W-1:0]     sum;
  logic [7:0]           hi_byte;

  // next byte closes a frame
  assign last_byte = (phase_r == PH_COLLECT) && (count_r == LAST_IDX);
  assign in_stall  = out_valid_r && out_stall && last_byte;
  assign in_accept = in_valid && !in_stall;

  // sync and frame sequencer
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    ctl       = '0;
    emit      = 1'b0;
    if (in_accept) begin
      case (phase_r)
        PH_SECOND: begin
          if (in_rx_byte == SYNC_SECOND) begin
            phase_nxt = PH_COLLECT;
            count_nxt = FIRST_DATA;
          end else begin
            phase_nxt = PH_HUNT;
            ctl.clear = 1'b1;
          end
        end
        PH_COLLECT: begin
          if (count_r < PAYLOAD_END) begin
            ctl.shift_en = 1'b1;
          end else if (count_r == PAYLOAD_END) begin
            ctl.hi_en = 1'b1;
          end
          if (count_r == LAST_IDX) begin
            emit      = 1'b1;
            phase_nxt = PH_HUNT;
            ctl.clear = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          if (in_rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_SECOND;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  shfp_payload_path u_path (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rx_byte (in_rx_byte),
    .payload (payload),
    .sum     (sum),
    .hi_byte (hi_byte)
  );

  // last byte is the low checksum byte
  assign sum_match = ({hi_byte, in_rx_byte} == {{(CHK_W-SUM_W){1'b0}}, sum});

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word0_r <= payload[31:0];
      word1_r <= payload[63:32];
      word2_r <= payload[95:64];
      ok_r    <= sum_match;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_word0 = word0_r;
  assign out_payload_word1 = word1_r;
  assign out_payload_word2 = word2_r;
  assign out_checksum_ok   = ok_r;

  // checks
  `SHFP_ASSERT_IMPL(a_no_overwrite, emit, !(out_valid_r && out_stall))
  `SHFP_ASSERT_NEXT(a_emit_restarts, emit, (phase_r == PH_HUNT) && out_valid_r)
  `SHFP_ASSERT_IMPL(a_collect_count, phase_r == PH_COLLECT, count_r >= FIRST_DATA)
  `SHFP_ASSERT_NEXT(a_first_sync,
    in_accept && (phase_r == PH_HUNT) && (in_rx_byte == SYNC_FIRST), phase_r == PH_SECOND)

endmodule
`default_nettype wire

// ===== tb/sync_header_frame_parser_unit_test.sv =====
`timescale 1ns / 1ps
module sync_header_frame_parser_unit_test;
  import shfp_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  localparam int PAYLOAD_LEN  = 12;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic        checksum_ok;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_payload_word0;
  logic [31:0] out_payload_word1;
  logic [31:0] out_payload_word2;
  logic        out_checksum_ok;

  // frames the parser owes us, oldest first
  frame_result_t pending_frames[$];
  int            error_count = 0;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  // shadow of the parser state
  phase_t      sh_phase = PH_HUNT;
  logic [4:0]  sh_count = '0;
  logic [15:0] sh_sum = '0;
  logic [95:0] sh_payload = '0;
  logic [7:0]  sh_high = '0;

  sync_header_frame_parser_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_word0 (out_payload_word0),
    .out_payload_word1 (out_payload_word1),
    .out_payload_word2 (out_payload_word2),
    .out_checksum_ok   (out_checksum_ok)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void restart_hunt();
    sh_phase   = PH_HUNT;
    sh_count   = '0;
    sh_sum     = '0;
    sh_payload = '0;
    sh_high    = '0;
  endfunction

  // advance the shadow state by one accepted byte
  function automatic void track_rx_byte(input logic [7:0] b);
    frame_result_t r;
    case (sh_phase)
      PH_SECOND: begin
        if (b == SYNC_SECOND) begin
          sh_phase = PH_COLLECT;
          sh_count = 5'd2;
        end else begin
          restart_hunt();
        end
      end
      PH_COLLECT: begin
        if (sh_count < PAYLOAD_END) begin
          sh_payload = {b, sh_payload[95:8]};
          sh_sum     = sh_sum + 16'(b);
        end else if (sh_count == PAYLOAD_END) begin
          sh_high = b;
        end
        sh_count = sh_count + 5'd1;
        if (sh_count >= FRAME_BYTES) begin
          r.word0       = sh_payload[31:0];
          r.word1       = sh_payload[63:32];
          r.word2       = sh_payload[95:64];
          r.checksum_ok = (sh_sum[15:8] == sh_high) && (sh_sum[7:0] == b);
          pending_frames.insert(pending_frames.size(), r);
          restart_hunt();
        end
      end
      default: begin
        if (b == SYNC_FIRST) begin
          sh_phase = PH_SECOND;
          sh_count = 5'd1;
        end
      end
    endcase
  endfunction

  // offer one byte request, with optional idle cycles first
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
  endtask

  // stop offering and let every owed frame come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  // sync pair, twelve payload bytes, checksum high then low
  task automatic send_frame(input bit good);
    logic [7:0]  body [PAYLOAD_LEN];
    logic [15:0] sum;
    logic [7:0]  chk_hi;
    logic [7:0]  chk_lo;
    int          fill;
    sum  = '0;
    fill = $urandom_range(0, 9);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        0:       body[i] = 8'hFF;
        1:       body[i] = 8'h00;
        2:       body[i] = 8'($urandom_range(0, 15));
        default: body[i] = 8'($urandom_range(0, 255));
      endcase
      sum = sum + 16'(body[i]);
    end
    chk_hi = sum[15:8];
    chk_lo = sum[7:0];
    if (!good) begin
      if ($urandom_range(0, 1)) chk_hi = chk_hi ^ 8'($urandom_range(1, 255));
      else chk_lo = chk_lo ^ 8'($urandom_range(1, 255));
    end
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < PAYLOAD_LEN; i++) send_byte(body[i]);
    send_byte(chk_hi);
    send_byte(chk_lo);
  endtask

  // line noise and broken sync pairs
  task automatic send_noise();
    logic [7:0] v;
    repeat ($urandom_range(1, 4)) begin
      v = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        if (v == SYNC_SECOND) v = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(v);
      end else begin
        send_byte(v);
      end
    end
  endtask

  task automatic random_frames(input int frames, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (frames) begin
      if ($urandom_range(0, 99) < 30) send_noise();
      send_frame($urandom_range(0, 99) < 75);
    end
  endtask

  // noise while hunting, wrong second byte, repeated first sync byte not rechecked
  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
  endtask

  // all-ones payload with its correct full 16-bit sum
  task automatic test_full_scale_frame();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    repeat (PAYLOAD_LEN) send_byte(8'hFF);
    send_byte(8'h0B);
    send_byte(8'hF4);
  endtask

  // zero payload, low checksum byte wrong
  task automatic test_checksum_mismatch();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    repeat (PAYLOAD_LEN) send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
  endtask

  task automatic test_no_idle();
    random_frames(15, 0, 0);
  endtask

  task automatic test_sender_idle();
    random_frames(15, 59, 0);
  endtask

  task automatic test_receiver_stall();
    random_frames(15, 0, 59);
  endtask

  task automatic test_both_idle();
    random_frames(15, 18, 18);
  endtask

  // receiver holds off while bytes keep coming, so the input backs up
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_requests++;
    repeat (4) send_frame(1'b1);
  endtask

  // sender pauses until all owed frames are out, then resumes
  task automatic test_drain_pause();
    random_frames(2, 18, 59);
    wait_drained();
    random_frames(2, 18, 18);
  endtask

  // receiver stall generator, with long holds on request
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        flag_mismatch("result with no frame pending");
      end else begin
        want = pending_frames.pop_front();
        if (out_payload_word0 !== want.word0)
          flag_mismatch($sformatf("word0 %h, want %h", out_payload_word0, want.word0));
        if (out_payload_word1 !== want.word1)
          flag_mismatch($sformatf("word1 %h, want %h", out_payload_word1, want.word1));
        if (out_payload_word2 !== want.word2)
          flag_mismatch($sformatf("word2 %h, want %h", out_payload_word2, want.word2));
        if (out_checksum_ok !== want.checksum_ok)
          flag_mismatch($sformatf("checksum_ok %b, want %b", out_checksum_ok,
                                  want.checksum_ok));
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sync_header_frame_parser_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sync_hunt();
    test_full_scale_frame();
    test_checksum_mismatch();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_frames.size() != 0)
      flag_mismatch($sformatf("%0d frames never came out", pending_frames.size()));
    if (error_count == 0) begin
      $display("sync_header_frame_parser_unit regression: pass");
    end else begin
      $display("sync_header_frame_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sync_header_frame_parser_unit.f =====
+incdir+design
design/shfp_pkg.sv
design/shfp_payload_path.sv
design/sync_header_frame_parser_unit.sv
tb/sync_header_frame_parser_unit_test.sv
